// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants for the buddy block allocator
// Holds field widths, command and result codes, and the front-to-back request.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ORD_W      = 5;
    localparam int OWN_W      = 16;
    localparam int SIZE_W     = 31;
    localparam int KIND_W     = 2;

    localparam logic [ORD_W-1:0] RESET_ORDER = 5'd10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OWNER  = 2'd2;

    // Classified request handed from front to back
    typedef struct packed {
        logic             cmd;
        logic             own_zero;
        logic [OWN_W-1:0] owner;
        logic [ORD_W-1:0] order;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [OWN_W-1:0]  result_value;
        logic              alloc_failed;
        logic              last;
    } t_res;

endpackage

// ===== design/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba_in_if / bba_out_if: valid-ready channels of the allocator
// Input requests and result items, each with source and sink modports.
// ----------------------------------------------------------------------------
interface bba_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [bba_pkg::OWN_W-1:0]  owner_id;
    logic [bba_pkg::SIZE_W-1:0] request_size;
    modport source (output valid, command, owner_id, request_size, input ready);
    modport sink   (input valid, command, owner_id, request_size, output ready);
endinterface

interface bba_out_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::KIND_W-1:0] result_kind;
    logic [bba_pkg::OWN_W-1:0]  result_value;
    logic                       alloc_failed;
    logic                       last;
    modport source (output valid, result_kind, result_value, alloc_failed, last,
                    input ready);
    modport sink   (input valid, result_kind, result_value, alloc_failed, last,
                    output ready);
endinterface

// ===== design/bba_front.sv =====
// ----------------------------------------------------------------------------
// bba_front: request classifier
// Rounds the size up to a power-of-two order and pushes into a 2-entry queue.
// ----------------------------------------------------------------------------
module bba_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bba_in_if.sink          i_req,
    output logic            o_q_valid,
    output bba_pkg::t_req   o_q_data,
    input  logic            i_q_pop
);
    logic [1:0]          r_cnt, n_cnt;
    logic                r_rd, n_rd;
    bba_pkg::t_req       r_q [2];
    bba_pkg::t_req       w_req;
    logic [bba_pkg::SIZE_W-1:0] w_m1;
    logic [bba_pkg::ORD_W-1:0]  w_ord;
    logic                w_push;

    // order = bit length of (size - 1); size 0 treated as 1
    always_comb begin
        w_m1  = (i_req.request_size == '0) ? '0 : i_req.request_size - 1'b1;
        w_ord = '0;
        for (int b = 0; b < bba_pkg::SIZE_W; b++) begin
            if (w_m1[b]) w_ord = bba_pkg::ORD_W'(b + 1);
        end
        w_req.cmd      = i_req.command;
        w_req.own_zero = (i_req.owner_id == '0);
        w_req.owner    = i_req.owner_id;
        w_req.order    = w_ord;
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_data    = r_q[r_rd];

    // queue pointers
    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        n_rd  = i_q_pop ? ~r_rd : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
        end
        if (w_push) r_q[r_rd ^ r_cnt[0]] <= w_req;
    end
endmodule

// ===== design/bba_back.sv =====
// ----------------------------------------------------------------------------
// bba_back: table sequencer
// Scans, splits with one-entry-per-cycle shifting, and streams query results.
// ----------------------------------------------------------------------------
module bba_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [bba_pkg::ORD_W-1:0] i_cfg_order,
    input  logic            i_q_valid,
    input  bba_pkg::t_req   i_q_data,
    output logic            o_q_pop,
    bba_out_if.source       o_res
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_QCNT  = 3'd4;
    localparam logic [2:0] S_QOWN  = 3'd5;

    logic [2:0] r_st;
    logic [bba_pkg::ORD_W-1:0] r_ord [bba_pkg::MAX_BLOCKS];
    logic [bba_pkg::OWN_W-1:0] r_own [bba_pkg::MAX_BLOCKS];
    logic [bba_pkg::CNT_W-1:0] r_bc;
    bba_pkg::t_req r_cur;
    logic [bba_pkg::CNT_W-1:0] r_i;         // scan / shift / query index
    logic [bba_pkg::CNT_W-1:0] r_big;       // first larger free block
    logic                      r_hbig;
    logic [bba_pkg::ORD_W:0]   r_spl;
    logic [bba_pkg::CNT_W-1:0] r_j;         // fill counter
    logic                      r_ov;
    bba_pkg::t_res             r_out;

    logic [bba_pkg::IDX_W-1:0] w_ix;
    logic                      w_free, w_can;
    logic [bba_pkg::ORD_W:0]   w_spl;
    logic [bba_pkg::CNT_W:0]   w_tot;

    assign w_ix    = r_i[bba_pkg::IDX_W-1:0];
    assign w_free  = (r_own[w_ix] == '0);
    assign w_can   = !r_ov || o_res.ready;
    assign o_q_pop = (r_st == S_IDLE) && i_q_valid && w_can;
    assign o_res.valid        = r_ov;
    assign o_res.result_kind  = r_out.result_kind;
    assign o_res.result_value = r_out.result_value;
    assign o_res.alloc_failed = r_out.alloc_failed;
    assign o_res.last         = r_out.last;
    assign w_spl = {1'b0, r_ord[r_big[bba_pkg::IDX_W-1:0]]} - {1'b0, r_cur.order};
    assign w_tot = {1'b0, r_bc} + (bba_pkg::CNT_W+1)'(w_spl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_st   <= S_IDLE;
            r_ov   <= 1'b0;
            r_bc   <= bba_pkg::CNT_W'(1);
            r_ord[0] <= i_rst_n ? i_cfg_order : bba_pkg::RESET_ORDER;
            for (int e = 0; e < bba_pkg::MAX_BLOCKS; e++) r_own[e] <= '0;
        end else begin
            if (r_ov && o_res.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_cur  <= i_q_data;
                        r_i    <= '0;
                        r_hbig <= 1'b0;
                        if (i_q_data.cmd == bba_pkg::CMD_QUERY) begin
                            r_st <= S_QCNT;
                        end else if (i_q_data.own_zero) begin
                            r_out <= '{bba_pkg::KIND_STATUS, '0, 1'b1, 1'b1};
                            r_ov  <= 1'b1;
                        end else begin
                            r_st <= S_SCAN;
                        end
                    end
                end
                // one entry per cycle: exact fit wins, else remember first larger
                S_SCAN: begin
                    if (r_i == r_bc) begin
                        if (!r_hbig || w_tot > (bba_pkg::CNT_W+1)'(bba_pkg::MAX_BLOCKS))
                        begin
                            r_out <= '{bba_pkg::KIND_STATUS, '0, 1'b1, 1'b1};
                            r_ov  <= 1'b1;
                            r_st  <= S_IDLE;
                        end else begin
                            r_spl <= w_spl;
                            r_i   <= r_bc;
                            r_st  <= S_SHIFT;
                        end
                    end else if (w_free && r_ord[w_ix] == r_cur.order) begin
                        r_own[w_ix] <= r_cur.owner;
                        r_out <= '{bba_pkg::KIND_STATUS, '0, 1'b0, 1'b1};
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end else begin
                        if (w_free && r_ord[w_ix] > r_cur.order && !r_hbig) begin
                            r_hbig <= 1'b1;
                            r_big  <= r_i;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                // move entries above the split block up, top first
                S_SHIFT: begin
                    if (r_i == r_big + 1'b1) begin
                        r_j  <= '0;
                        r_st <= S_FILL;
                    end else begin
                        r_ord[bba_pkg::IDX_W'(r_i - 1'b1 + bba_pkg::CNT_W'(r_spl))]
                            <= r_ord[bba_pkg::IDX_W'(r_i - 1'b1)];
                        r_own[bba_pkg::IDX_W'(r_i - 1'b1 + bba_pkg::CNT_W'(r_spl))]
                            <= r_own[bba_pkg::IDX_W'(r_i - 1'b1)];
                        r_i <= r_i - 1'b1;
                    end
                end
                // write the freed upper halves, then claim the split block
                S_FILL: begin
                    if (r_j == bba_pkg::CNT_W'(r_spl)) begin
                        r_ord[r_big[bba_pkg::IDX_W-1:0]] <= r_cur.order;
                        r_own[r_big[bba_pkg::IDX_W-1:0]] <= r_cur.owner;
                        r_bc  <= r_bc + bba_pkg::CNT_W'(r_spl);
                        r_out <= '{bba_pkg::KIND_STATUS, '0, 1'b0, 1'b1};
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end else begin
                        r_ord[bba_pkg::IDX_W'(r_big + 1'b1 + r_j)]
                            <= r_cur.order + bba_pkg::ORD_W'(r_j);
                        r_own[bba_pkg::IDX_W'(r_big + 1'b1 + r_j)] <= '0;
                        r_j <= r_j + 1'b1;
                    end
                end
                S_QCNT: begin
                    if (w_can) begin
                        r_out <= '{bba_pkg::KIND_COUNT, bba_pkg::OWN_W'(r_bc), 1'b0,
                                   (r_bc == '0)};
                        r_ov  <= 1'b1;
                        r_st  <= (r_bc == '0) ? S_IDLE : S_QOWN;
                    end
                end
                S_QOWN: begin
                    if (w_can) begin
                        r_out <= '{bba_pkg::KIND_OWNER, r_own[w_ix], 1'b0,
                                   (r_i + 1'b1 == r_bc)};
                        r_ov  <= 1'b1;
                        r_i   <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_bc) r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator: power-of-two block table allocator
// Front classifies requests into a short queue; back walks and edits the table.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_req     in   valid/ready     command, owner_id, request_size
//  o_res     out  valid/ready     result_kind, result_value, alloc_failed, last
//  cfg       in   i_cfg_we        i_cfg_data = total_order
//
// Allocate: the sequencer takes the request and scans the table entry by entry
// (with a closing step when no exact fit exists); when a larger free block fits,
// it shifts the entries above it, fills the split halves and loads the status.
// Query: the sequencer takes it, then the count and one owner per cycle while ready.
// Reset (synchronous) or a total_order write restores one free block.
// A stalled result register holds the sequencer before it takes a request and
// during query output; the queue keeps taking up to two requests meanwhile.
module buddy_block_allocator (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [bba_pkg::ORD_W-1:0] i_cfg_data,
    bba_in_if.sink    i_req,
    bba_out_if.source o_res
);
    logic          w_qv, w_pop;
    bba_pkg::t_req w_qd;

    bba_front u_front (
        .i_clk, .i_rst_n, .i_req,
        .o_q_valid(w_qv), .o_q_data(w_qd), .i_q_pop(w_pop)
    );

    bba_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_order(i_cfg_data),
        .i_q_valid(w_qv), .i_q_data(w_qd), .o_q_pop(w_pop), .o_res
    );
endmodule
